@@ hdl/ps2mct_pkg.sv @@
// Package for the PS/2 mouse cursor tracker.
// Holds the item types, register indexes, packet byte positions and reset constants.
// Has no dependencies; used by ps2mct_axis_update and ps2_mouse_cursor_tracker.
package ps2mct_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int SCREEN_BITS        = 12;
   localparam int CSR_INDEX_BITS     = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd1024;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd768;

   localparam int POS_X_RESET = 512;
   localparam int POS_Y_RESET = 384;

   // position of the next byte within a packet
   localparam logic [1:0] IDX_HEADER = 2'd0;
   localparam logic [1:0] IDX_XBYTE  = 2'd1;
   localparam logic [1:0] IDX_YBYTE  = 2'd2;

   // header byte bit positions
   localparam int LEFT_BIT  = 0;
   localparam int SYNC_BIT  = 3;
   localparam int XSIGN_BIT = 4;
   localparam int YSIGN_BIT = 5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       from_aux;
   } req_type;

   typedef struct packed {
      logic [SCREEN_BITS-1:0] cursor_x;
      logic [SCREEN_BITS-1:0] cursor_y;
      logic                   left_pressed;
   } rsp_type;

   // 9-bit two's-complement movement: sign from the header, low byte from the packet
   typedef struct packed {
      logic       neg;
      logic [7:0] low;
   } delta_type;

endpackage

@@ hdl/ps2mct_axis_update.sv @@
// One cursor axis: applies a 9-bit movement to a position and clamps to 0..bound.
// Depends on ps2mct_pkg for delta_type and SCREEN_BITS.
module ps2mct_axis_update #(
   parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]              pos,
   input  ps2mct_pkg::delta_type              delta,
   input  logic                               subtract,
   input  logic [ps2mct_pkg::SCREEN_BITS-1:0] bound,
   output logic [COORD_BITS-1:0]              pos_next
);

   localparam int SUM_BITS = (COORD_BITS + 2 > ps2mct_pkg::SCREEN_BITS + 2) ?
                             COORD_BITS + 2 : ps2mct_pkg::SCREEN_BITS + 2;

   logic signed [SUM_BITS-1:0] pos_wide;
   logic signed [SUM_BITS-1:0] delta_wide;
   logic signed [SUM_BITS-1:0] bound_wide;
   logic signed [SUM_BITS-1:0] sum;
   logic signed [SUM_BITS-1:0] clamped;

   always_comb begin
      pos_wide   = $signed(SUM_BITS'(pos));
      bound_wide = $signed(SUM_BITS'(bound));
      delta_wide = SUM_BITS'($signed({delta.neg, delta.low}));
      if (subtract) begin
         sum = pos_wide - delta_wide;
      end else begin
         sum = pos_wide + delta_wide;
      end
      if (sum < 0) begin
         clamped = '0;
      end else if (sum > bound_wide) begin
         clamped = bound_wide;
      end else begin
         clamped = sum;
      end
      pos_next = COORD_BITS'(clamped);
   end

endmodule

@@ hdl/ps2_mouse_cursor_tracker.sv @@
// Top level of the PS/2 mouse cursor tracker: packet assembly, cursor state, result register.
// Depends on ps2mct_pkg and ps2mct_axis_update.
//
//   channel  ports                          direction  item
//   req      req_valid/req_ready/req_data   in         controller byte + aux flag
//   rsp      rsp_valid/rsp_ready/rsp_data   out        cursor x, y, left button
//   csr      csr_we/csr_index/csr_wdata     in         screen width / height
//
// The third byte of a packet updates the cursor in the same cycle it is taken, and its
// item is in the result register on the next cycle.
// A byte is accepted whenever the result register is empty or is being taken.
// Reset sets the cursor to its home position and the screen size to its defaults.
module ps2_mouse_cursor_tracker #(
   parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ps2mct_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ps2mct_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_we,
   input  logic [ps2mct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mct_pkg::SCREEN_BITS-1:0]    csr_wdata
);

   logic [ps2mct_pkg::SCREEN_BITS-1:0] width_ff, width_in;
   logic [ps2mct_pkg::SCREEN_BITS-1:0] height_ff, height_in;
   logic [1:0]            byte_index_ff, byte_index_in;
   logic [7:0]            header_ff, header_in;
   logic [7:0]            xbyte_ff, xbyte_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ps2mct_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  emit;
   logic [COORD_BITS-1:0] new_x;
   logic [COORD_BITS-1:0] new_y;
   ps2mct_pkg::delta_type dx;
   ps2mct_pkg::delta_type dy;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dx.neg = header_ff[ps2mct_pkg::XSIGN_BIT];
   assign dx.low = xbyte_ff;
   assign dy.neg = header_ff[ps2mct_pkg::YSIGN_BIT];
   assign dy.low = req_data.data_byte;

   ps2mct_axis_update #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .pos      (pos_x_ff),
      .delta    (dx),
      .subtract (1'b0),
      .bound    (width_ff),
      .pos_next (new_x)
   );

   // mouse Y is up-positive, screen Y is down-positive
   ps2mct_axis_update #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .pos      (pos_y_ff),
      .delta    (dy),
      .subtract (1'b1),
      .bound    (height_ff),
      .pos_next (new_y)
   );

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      byte_index_in = byte_index_ff;
      header_in     = header_ff;
      xbyte_in      = xbyte_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      emit          = 1'b0;

      if (csr_we) begin
         case (csr_index)
            ps2mct_pkg::CSR_SCREEN_WIDTH:  width_in  = csr_wdata;
            ps2mct_pkg::CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept && req_data.from_aux) begin
         case (byte_index_ff)
            ps2mct_pkg::IDX_HEADER: begin
               // drop a header without the always-one bit to resync
               if (req_data.data_byte[ps2mct_pkg::SYNC_BIT]) begin
                  header_in     = req_data.data_byte;
                  byte_index_in = ps2mct_pkg::IDX_XBYTE;
               end
            end
            ps2mct_pkg::IDX_XBYTE: begin
               xbyte_in      = req_data.data_byte;
               byte_index_in = ps2mct_pkg::IDX_YBYTE;
            end
            default: begin
               byte_index_in = ps2mct_pkg::IDX_HEADER;
               pos_x_in      = new_x;
               pos_y_in      = new_y;
               emit          = 1'b1;
            end
         endcase
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_data_in.cursor_x     = ps2mct_pkg::SCREEN_BITS'(new_x);
         rsp_data_in.cursor_y     = ps2mct_pkg::SCREEN_BITS'(new_y);
         rsp_data_in.left_pressed = header_ff[ps2mct_pkg::LEFT_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= ps2mct_pkg::SCREEN_WIDTH_RESET;
         height_ff     <= ps2mct_pkg::SCREEN_HEIGHT_RESET;
         byte_index_ff <= ps2mct_pkg::IDX_HEADER;
         pos_x_ff      <= COORD_BITS'(ps2mct_pkg::POS_X_RESET);
         pos_y_ff      <= COORD_BITS'(ps2mct_pkg::POS_Y_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         byte_index_ff <= byte_index_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff   <= header_in;
      xbyte_ff    <= xbyte_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a third aux byte always leaves an item waiting on the next cycle
   a_third_byte_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.from_aux && (byte_index_ff == ps2mct_pkg::IDX_YBYTE)
      |=> rsp_valid && (rsp_data.left_pressed == $past(header_ff[ps2mct_pkg::LEFT_BIT])))
      else $error("third packet byte did not produce a cursor item");

   // bytes from the keyboard port leave packet and cursor state alone
   a_non_aux_ignored: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.from_aux
      |=> $stable(byte_index_ff) && $stable(pos_x_ff) && $stable(pos_y_ff))
      else $error("non-aux byte changed tracker state");

   // a header without the sync bit keeps the tracker waiting for a header
   a_bad_header_dropped: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.from_aux && (byte_index_ff == ps2mct_pkg::IDX_HEADER)
      && !req_data.data_byte[ps2mct_pkg::SYNC_BIT]
      |=> (byte_index_ff == ps2mct_pkg::IDX_HEADER))
      else $error("unsynced header byte was not dropped");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (byte_index_ff == ps2mct_pkg::IDX_HEADER) || (byte_index_ff == ps2mct_pkg::IDX_XBYTE)
      || (byte_index_ff == ps2mct_pkg::IDX_YBYTE))
      else $error("packet byte index out of range");

endmodule
